FILE: hw/rtl/fthm_pkg.sv
// shared types and constants for the frame time hitch monitor
package fthm_pkg;

    // field widths
    localparam int TS_W     = 48;
    localparam int CFG_W    = 20;
    localparam int DELTA_W  = 20;
    localparam int CLAMP_W  = 18;
    localparam int FRAME_W  = 32;
    localparam int STAT_W   = 18;
    localparam int CNT_W    = 7;

    // timing constants in microseconds
    localparam logic [CLAMP_W-1:0] DELTA_CLAMP_US    = 18'd250000;
    localparam logic [CFG_W-1:0]   DEFAULT_PERIOD_US = 20'd16667;

    // default statistics window length
    localparam int unsigned WINDOW_FRAMES_DEF = 64;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_EN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP    = 2'd2;

    // max * 4 / 5 as peak * ceil(2^23 / 5) >> 21, exact for peak below 2^18
    localparam int P95_MUL_W = 21;
    localparam logic [P95_MUL_W-1:0] P95_MUL = 21'd1677722;
    localparam int P95_SHIFT = 21;

    // input transaction
    typedef struct packed {
        logic [TS_W-1:0] timestamp_us;
        logic            restart;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [DELTA_W-1:0] delta_us;
        logic [TS_W-1:0]    elapsed_us;
        logic [FRAME_W-1:0] frame_number;
        logic               hitch;
        logic               stats_valid;
        logic [STAT_W-1:0]  window_max_us;
        logic [STAT_W-1:0]  window_avg_us;
        logic [STAT_W-1:0]  window_p95_us;
        logic [CNT_W-1:0]   window_hitches;
        logic [CNT_W-1:0]   window_frames;
    } t_out;

    // per-frame measurement handed from the delta stage to the window stage
    typedef struct packed {
        logic               first;
        logic [DELTA_W-1:0] delta_us;
        logic [CLAMP_W-1:0] clamped_us;
        logic [TS_W-1:0]    elapsed_us;
        logic [FRAME_W-1:0] frame_number;
        logic               hitch;
    } t_frame_meas;

endpackage

FILE: hw/rtl/frame_time_hitch_monitor_top.sv
// frame time monitor: input register, delta stage, window stage, statistics output
// throughput: one transaction per cycle; a stalled output freezes the whole
//   four-stage pipeline, so the input stalls only while the output is held
// reset: synchronous, clears pipeline valids, frame count and window, sets the
//   first-frame flag, and returns the configuration registers to their defaults
module frame_time_hitch_monitor_top
    import fthm_pkg::*;
#(
    parameter int unsigned WINDOW_FRAMES = WINDOW_FRAMES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  t_in                  i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out                 o_data,
    input  logic                 i_stall
);

    // configuration registers
    logic [CFG_W-1:0] r_target_period;
    logic             r_fixed_en;
    logic [CFG_W-1:0] r_fixed_step;

    // input register
    logic        r_a_valid;
    t_in         r_a_data;

    // delta stage state and output
    logic               r_first_pending;
    logic [TS_W-1:0]    r_origin;
    logic [TS_W-1:0]    r_prev;
    logic [FRAME_W-1:0] r_frame_count;
    logic               r_b_valid;
    t_frame_meas        r_b_meas;

    logic               w_adv;
    logic               w_out_valid;
    logic               w_first;
    logic [TS_W-1:0]    w_elapsed;
    logic [TS_W-1:0]    w_diff;
    logic [CLAMP_W-1:0] w_clamped;
    logic [CFG_W-1:0]   w_period;
    logic               w_hitch;
    logic [FRAME_W-1:0] n_frame_count;

    // pipeline moves unless a held result is stalled
    assign w_adv   = !w_out_valid || !i_stall;
    assign o_stall = !w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_period <= DEFAULT_PERIOD_US;
            r_fixed_en      <= 1'b0;
            r_fixed_step    <= DEFAULT_PERIOD_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET_PERIOD: r_target_period <= i_cfg_data;
                CFG_FIXED_EN:      r_fixed_en      <= i_cfg_data[0];
                CFG_FIXED_STEP:    r_fixed_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_a_data <= i_data;
        end
    end

    // delta, clamp and hitch detection
    always_comb begin
        w_first       = r_a_data.restart || r_first_pending;
        w_elapsed     = r_a_data.timestamp_us - r_origin;
        w_diff        = r_a_data.timestamp_us - r_prev;
        w_clamped     = (w_diff > TS_W'(DELTA_CLAMP_US)) ? DELTA_CLAMP_US
                                                          : w_diff[CLAMP_W-1:0];
        w_period      = (r_target_period == '0) ? DEFAULT_PERIOD_US : r_target_period;
        w_hitch       = (CFG_W+1)'(w_clamped) > {w_period, 1'b0};
        n_frame_count = r_frame_count + FRAME_W'(1);
    end

    // delta stage state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pending <= 1'b1;
            r_frame_count   <= '0;
            r_b_valid       <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_first_pending <= 1'b0;
                r_frame_count   <= w_first ? '0 : n_frame_count;
            end
        end
    end

    // origin, previous start and measurement payload
    always_ff @(posedge i_clk) begin
        if (w_adv && r_a_valid) begin
            r_prev <= r_a_data.timestamp_us;
            if (w_first) begin
                r_origin              <= r_a_data.timestamp_us;
                r_b_meas.first        <= 1'b1;
                r_b_meas.delta_us     <= '0;
                r_b_meas.clamped_us   <= '0;
                r_b_meas.elapsed_us   <= '0;
                r_b_meas.frame_number <= '0;
                r_b_meas.hitch        <= 1'b0;
            end else begin
                r_b_meas.first        <= 1'b0;
                r_b_meas.delta_us     <= r_fixed_en ? r_fixed_step
                                                    : DELTA_W'(w_clamped);
                r_b_meas.clamped_us   <= w_clamped;
                r_b_meas.elapsed_us   <= w_elapsed;
                r_b_meas.frame_number <= n_frame_count;
                r_b_meas.hitch        <= w_hitch;
            end
        end
    end

    // window accumulation and statistics
    fthm_window #(
        .WINDOW_FRAMES(WINDOW_FRAMES)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_b_valid),
        .i_meas  (r_b_meas),
        .o_valid (w_out_valid),
        .o_data  (o_data)
    );

    assign o_valid = w_out_valid;

endmodule

FILE: hw/rtl/fthm_window.sv
// window accumulation stage and statistics output stage
module fthm_window
    import fthm_pkg::*;
#(
    parameter int unsigned WINDOW_FRAMES = WINDOW_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_frame_meas i_meas,
    output logic        o_valid,
    output t_out        o_data
);

    localparam int POS_W     = $clog2(WINDOW_FRAMES + 1);
    localparam int SUM_W     = CLAMP_W + $clog2(WINDOW_FRAMES);
    // exact floor(sum / WINDOW_FRAMES) as (sum * AVG_MUL) >> AVG_SHIFT
    localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_FRAMES);
    localparam longint unsigned AVG_MUL_L =
        ((64'd1 << AVG_SHIFT) + WINDOW_FRAMES - 1) / WINDOW_FRAMES;
    localparam logic [SUM_W:0]    AVG_MUL  = AVG_MUL_L[SUM_W:0];
    localparam logic [POS_W-1:0]  POS_FULL = POS_W'(WINDOW_FRAMES);
    localparam logic [CNT_W-1:0]  FRAMES_OUT = CNT_W'(WINDOW_FRAMES);

    // window state
    logic [CLAMP_W-1:0] r_peak;
    logic [SUM_W-1:0]   r_sum;
    logic [POS_W-1:0]   r_hits;
    logic [POS_W-1:0]   r_pos;

    // window stage registers
    logic               r_c_valid;
    t_frame_meas        r_c_meas;
    logic               r_c_stats;
    logic [CLAMP_W-1:0] r_c_peak;
    logic [SUM_W-1:0]   r_c_sum;
    logic [POS_W-1:0]   r_c_hits;

    // output registers
    logic               r_d_valid;
    t_out               r_d_data;

    logic [CLAMP_W-1:0]     n_peak;
    logic [SUM_W-1:0]       n_sum;
    logic [POS_W-1:0]       n_hits;
    logic [POS_W-1:0]       n_pos;
    logic                   w_done;
    logic [2*SUM_W:0]       w_avg_prod;
    logic [CLAMP_W+P95_MUL_W-1:0] w_p95_prod;

    // next window values for a frame that enters the window
    always_comb begin
        n_peak = (i_meas.clamped_us > r_peak) ? i_meas.clamped_us : r_peak;
        n_sum  = r_sum + SUM_W'(i_meas.clamped_us);
        n_pos  = r_pos + POS_W'(1);
        n_hits = r_hits + POS_W'(i_meas.hitch);
        w_done = (n_pos == POS_FULL);
    end

    // window state and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak    <= '0;
            r_sum     <= '0;
            r_hits    <= '0;
            r_pos     <= '0;
            r_c_valid <= 1'b0;
            r_c_stats <= 1'b0;
        end else if (i_adv) begin
            r_c_valid <= i_valid;
            if (i_valid) begin
                if (i_meas.first || w_done) begin
                    r_peak <= '0;
                    r_sum  <= '0;
                    r_hits <= '0;
                    r_pos  <= '0;
                end else begin
                    r_peak <= n_peak;
                    r_sum  <= n_sum;
                    r_hits <= n_hits;
                    r_pos  <= n_pos;
                end
                r_c_stats <= !i_meas.first && w_done;
            end
        end
    end

    // window stage payload, statistics zero unless the window completes
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_c_meas <= i_meas;
            if (!i_meas.first && w_done) begin
                r_c_peak <= n_peak;
                r_c_sum  <= n_sum;
                r_c_hits <= n_hits;
            end else begin
                r_c_peak <= '0;
                r_c_sum  <= '0;
                r_c_hits <= '0;
            end
        end
    end

    // average and 4/5 of the peak (reported as p95) by reciprocal multiplication
    always_comb begin
        w_avg_prod = (2*SUM_W+1)'(r_c_sum) * (2*SUM_W+1)'(AVG_MUL);
        w_p95_prod = (CLAMP_W+P95_MUL_W)'(r_c_peak) * (CLAMP_W+P95_MUL_W)'(P95_MUL);
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_adv && r_c_valid) begin
            r_d_data.delta_us       <= r_c_meas.delta_us;
            r_d_data.elapsed_us     <= r_c_meas.elapsed_us;
            r_d_data.frame_number   <= r_c_meas.frame_number;
            r_d_data.hitch          <= r_c_meas.hitch;
            r_d_data.stats_valid    <= r_c_stats;
            r_d_data.window_max_us  <= r_c_peak;
            r_d_data.window_avg_us  <= w_avg_prod[AVG_SHIFT +: STAT_W];
            r_d_data.window_p95_us  <= w_p95_prod[P95_SHIFT +: STAT_W];
            r_d_data.window_hitches <= CNT_W'(r_c_hits);
            r_d_data.window_frames  <= r_c_stats ? FRAMES_OUT : '0;
        end
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d_data;

endmodule

FILE: sim/frame_time_hitch_monitor_top_tb.sv
// self-checking testbench for the frame time hitch monitor top level
module frame_time_hitch_monitor_top_tb;
    import fthm_pkg::*;

    localparam int WINDOW_LEN = WINDOW_FRAMES_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int NUM_PHASES = 6;
    // index past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    t_in                  i_data = '0;
    logic                 o_stall;
    logic                 o_valid;
    t_out                 o_data;
    logic                 i_stall = 1'b0;

    frame_time_hitch_monitor_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // frame events waiting to be sent and frame reports waiting to arrive
    t_in  pending_events[$];
    t_out expected_reports[$];

    int errors = 0;
    int reports_seen = 0;
    int cycles = 0;
    int gap_left = 0;
    int drv_calm = 0;
    int stall_left = 0;
    int mon_calm = 0;
    logic [TS_W-1:0] stim_ts = '0;

    // predictor copy of the registers
    logic [CFG_W-1:0] period_reg;
    logic             fixed_en_reg;
    logic [CFG_W-1:0] fixed_step_reg;

    // predictor copy of the frame history and window
    logic             first_pending;
    logic [TS_W-1:0]  origin_ts;
    logic [TS_W-1:0]  prev_start_ts;
    logic [31:0]      frame_count;
    int unsigned      win_peak;
    int unsigned      win_total;
    int unsigned      win_hitches;
    int unsigned      win_position;

    function automatic void clear_history();
        first_pending = 1'b1;
        origin_ts = '0;
        prev_start_ts = '0;
        frame_count = '0;
        win_peak = 0;
        win_total = 0;
        win_hitches = 0;
        win_position = 0;
    endfunction

    // expected report for one frame event, updates the history
    function automatic t_out predict_frame(input t_in ev);
        t_out r;
        logic [TS_W-1:0]    raw;
        logic [CLAMP_W-1:0] clamped;
        logic [CFG_W-1:0]   period;
        logic [CFG_W:0]     twice;
        r = '0;
        if (ev.restart) begin
            clear_history();
        end
        if (first_pending) begin
            first_pending = 1'b0;
            origin_ts = ev.timestamp_us;
            prev_start_ts = ev.timestamp_us;
            return r;
        end
        raw = ev.timestamp_us - prev_start_ts;
        prev_start_ts = ev.timestamp_us;
        clamped = (raw > DELTA_CLAMP_US) ? DELTA_CLAMP_US : raw[CLAMP_W-1:0];
        frame_count = frame_count + 32'd1;
        period = (period_reg != '0) ? period_reg : DEFAULT_PERIOD_US;
        twice = {period, 1'b0};
        r.hitch = ({3'b0, clamped} > twice);
        r.delta_us = fixed_en_reg ? fixed_step_reg : DELTA_W'(clamped);
        r.elapsed_us = ev.timestamp_us - origin_ts;
        r.frame_number = frame_count;
        // window accumulation uses the measured delta even in fixed mode
        if (clamped > win_peak) begin
            win_peak = clamped;
        end
        win_total += clamped;
        win_position++;
        if (r.hitch) begin
            win_hitches++;
        end
        if (win_position >= WINDOW_LEN) begin
            r.stats_valid = 1'b1;
            r.window_max_us = STAT_W'(win_peak);
            r.window_avg_us = STAT_W'(win_total / win_position);
            r.window_p95_us = STAT_W'((win_peak * 4) / 5);
            r.window_hitches = CNT_W'(win_hitches);
            r.window_frames = CNT_W'(win_position);
            win_peak = 0;
            win_total = 0;
            win_hitches = 0;
            win_position = 0;
        end
        return r;
    endfunction

    // idle length: mostly short, a few long, with calm stretches of none
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at report %0d: %s", reports_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // register write, called right after a rising edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TARGET_PERIOD: period_reg = value;
            CFG_FIXED_EN:      fixed_en_reg = value[0];
            CFG_FIXED_STEP:    fixed_step_reg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic queue_event(input logic [TS_W-1:0] ts, input logic restart);
        t_in ev;
        ev.timestamp_us = ts;
        ev.restart = restart;
        pending_events.push_back(ev);
        stim_ts = ts;
    endtask

    // mostly steady frame sequences, with hitches, boundaries, wraps and noise
    task automatic queue_random_event();
        int r;
        logic [63:0] wide;
        logic [TS_W-1:0] period;
        r = $urandom_range(0, 999);
        wide = {$urandom, $urandom};
        period = TS_W'((period_reg != '0) ? period_reg : DEFAULT_PERIOD_US);
        if (r < 3) begin
            queue_event(wide[TS_W-1:0], 1'b1);
        end else if (r < 5) begin
            // restart just below the wrap point
            queue_event('1 - TS_W'($urandom_range(0, 200000)), 1'b1);
        end else if (r < 15) begin
            queue_event(wide[TS_W-1:0], 1'b0);
        end else if (r < 30) begin
            queue_event(stim_ts - TS_W'($urandom_range(1, 100000)), 1'b0);
        end else if (r < 80) begin
            queue_event(stim_ts + TS_W'($urandom_range(30000, 400000)), 1'b0);
        end else if (r < 100) begin
            case ($urandom_range(0, 3))
                0: queue_event(stim_ts + 2 * period, 1'b0);
                1: queue_event(stim_ts + 2 * period + 1, 1'b0);
                2: queue_event(stim_ts + 250000, 1'b0);
                default: queue_event(stim_ts + 250001, 1'b0);
            endcase
        end else begin
            queue_event(stim_ts + TS_W'($urandom_range(12000, 21000)), 1'b0);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || i_valid || expected_reports.size() != 0);
    endtask

    // register settings per phase: extremes first, then random, then defaults
    task automatic configure_phase(input int phase);
        @(posedge i_clk);
        case (phase)
            0: begin
                cfg_write(CFG_TARGET_PERIOD, '0);
                cfg_write(CFG_FIXED_EN, 20'd0);
                cfg_write(CFG_FIXED_STEP, '0);
                cfg_write(CFG_IDX_UNUSED, CFG_W'($urandom));
            end
            1: begin
                cfg_write(CFG_TARGET_PERIOD, 20'd1);
                cfg_write(CFG_FIXED_EN, 20'd1);
                cfg_write(CFG_FIXED_STEP, 20'd1000000);
            end
            2: begin
                cfg_write(CFG_TARGET_PERIOD, 20'd1000000);
                cfg_write(CFG_FIXED_STEP, '0);
            end
            3: begin
                cfg_write(CFG_TARGET_PERIOD, 20'd124999);
                cfg_write(CFG_FIXED_EN, 20'd0);
                cfg_write(CFG_FIXED_STEP, CFG_W'($urandom_range(0, 1000000)));
            end
            4: begin
                cfg_write(CFG_TARGET_PERIOD, CFG_W'($urandom_range(0, 60000)));
                cfg_write(CFG_FIXED_EN, CFG_W'($urandom_range(0, 1)));
                cfg_write(CFG_FIXED_STEP, CFG_W'($urandom_range(0, 1000000)));
            end
            default: begin
                cfg_write(CFG_TARGET_PERIOD, DEFAULT_PERIOD_US);
                cfg_write(CFG_FIXED_EN, 20'd0);
                cfg_write(CFG_FIXED_STEP, DEFAULT_PERIOD_US);
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // main sequence: reset, directed events, then randomized phases
    initial begin
        period_reg = DEFAULT_PERIOD_US;
        fixed_en_reg = 1'b0;
        fixed_step_reg = DEFAULT_PERIOD_US;
        clear_history();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first event, hitch and clamp boundaries, wrap and restart cases
        queue_event(48'd0, 1'b0);
        queue_event(stim_ts + 16667, 1'b0);
        queue_event(stim_ts + 33334, 1'b0);
        queue_event(stim_ts + 33335, 1'b0);
        queue_event(stim_ts + 250000, 1'b0);
        queue_event(stim_ts + 250001, 1'b0);
        queue_event(stim_ts + 48'h8000_0000_0000, 1'b0);
        queue_event(stim_ts - 1, 1'b0);
        queue_event(stim_ts, 1'b0);
        queue_event(48'hFFFF_FFFF_FFF0, 1'b1);
        queue_event(48'h0000_0000_0010, 1'b0);
        queue_event(stim_ts + 16667, 1'b0);
        queue_event(48'h0, 1'b1);
        queue_event(48'h5555_5555_5555, 1'b1);
        queue_event(stim_ts + 1, 1'b0);
        queue_event(48'hAAAA_AAAA_AAAA, 1'b0);
        queue_event(48'hFFFF_FFFF_FFFF, 1'b0);
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            configure_phase(phase);
            @(negedge i_clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_random_event();
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            report_mismatch("reports still outstanding at end of run");
        end
        if (errors == 0) begin
            $display("frame_time_hitch_monitor_top_tb OK");
        end else begin
            $display("frame_time_hitch_monitor_top_tb NOT OK");
        end
        $finish;
    end

    // event driver with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_reports.push_back(predict_frame(i_data));
            end
            if (i_valid && o_stall) begin
                // hold the stalled transaction
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                i_valid <= 1'b1;
                i_data <= pending_events.pop_front();
                gap_left = pick_idle(drv_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // report monitor with random stalls
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("report arrived with none expected");
                end else begin
                    want = expected_reports.pop_front();
                    check_field("delta_us", 64'(o_data.delta_us), 64'(want.delta_us));
                    check_field("elapsed_us", 64'(o_data.elapsed_us),
                                64'(want.elapsed_us));
                    check_field("frame_number", 64'(o_data.frame_number),
                                64'(want.frame_number));
                    check_field("hitch", 64'(o_data.hitch), 64'(want.hitch));
                    check_field("stats_valid", 64'(o_data.stats_valid),
                                64'(want.stats_valid));
                    check_field("window_max_us", 64'(o_data.window_max_us),
                                64'(want.window_max_us));
                    check_field("window_avg_us", 64'(o_data.window_avg_us),
                                64'(want.window_avg_us));
                    check_field("window_p95_us", 64'(o_data.window_p95_us),
                                64'(want.window_p95_us));
                    check_field("window_hitches", 64'(o_data.window_hitches),
                                64'(want.window_hitches));
                    check_field("window_frames", 64'(o_data.window_frames),
                                64'(want.window_frames));
                end
                reports_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_idle(mon_calm);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("frame_time_hitch_monitor_top_tb NOT OK");
            $finish;
        end
    end

endmodule
